// ===== sv/kcs_pkg.sv =====
// Shared constants for the k-closest point selector.
// No dependencies; imported by every module of the block.
package kcs_pkg;

    // default sizing
    localparam int DEF_MAX_KEEP   = 16;
    localparam int DEF_COORD_BITS = 16;

    // fixed field widths
    localparam int KEEP_W     = 5;
    localparam int OUT_DIST_W = 33;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REF_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 2'd2;

    // queue between distance front end and store
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== sv/k_closest_stream_select.sv =====
// Top level of the k-closest point selector: config registers and the
// front end / queue / store chain. Depends on kcs_pkg, kcs_front,
// kcs_queue and kcs_back.
//
//  channel   dir  handshake                 payload
//  s         in   i_s_tvalid / o_s_tready   tdata: pt_x, pt_y; tlast: set_end
//  m         out  o_m_tvalid / i_m_tready   tdata: out_x, out_y, out_dist; tlast: out_last
//  cfg       in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A point is taken each cycle while the four-entry queue has room; the
// distance front end registers its differences, then its squares, before
// the point is queued. The store handles one queued point per cycle while
// not emitting. A point marked set_end then makes the store shift its held
// points out through the output register; the queue is not drained meanwhile.
// Reset is synchronous; the store needs no clearing pass.
module k_closest_stream_select import kcs_pkg::*; #(
    parameter int MAX_KEEP   = DEF_MAX_KEEP,
    parameter int COORD_BITS = DEF_COORD_BITS,
    localparam int ITW = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int OTW = ((2 * COORD_BITS + OUT_DIST_W + 7) / 8) * 8,
    localparam int CFW = (COORD_BITS > KEEP_W) ? COORD_BITS : KEEP_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFW-1:0]       i_cfg_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [ITW-1:0]       i_s_tdata,   // pt_x, pt_y
    input  logic                 i_s_tlast,   // set_end
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OTW-1:0]       o_m_tdata,   // out_x, out_y, out_dist
    output logic                 o_m_tlast    // out_last
);

    localparam int CB = COORD_BITS;
    localparam int IW = 4 * CB + 2;

    logic [CB-1:0]     r_ref_x, r_ref_y;
    logic [KEEP_W-1:0] r_keep;

    logic              q_push, q_pop, q_valid;
    logic [IW-1:0]     q_in, q_out;
    logic [QCNT_W-1:0] q_count;
    logic [CB-1:0]     ox, oy;
    logic [OUT_DIST_W-1:0] od;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
            r_keep  <= KEEP_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_REF_X:      r_ref_x <= i_cfg_data[CB-1:0];
                REG_REF_Y:      r_ref_y <= i_cfg_data[CB-1:0];
                REG_KEEP_COUNT: r_keep  <= i_cfg_data[KEEP_W-1:0];
                default: ;
            endcase
        end
    end

    kcs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ref_x   (r_ref_x),
        .i_ref_y   (r_ref_y),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_pt_x    (i_s_tdata[CB-1:0]),
        .i_pt_y    (i_s_tdata[2*CB-1:CB]),
        .i_set_end (i_s_tlast),
        .i_q_count (q_count),
        .o_push    (q_push),
        .o_item    (q_in)
    );

    kcs_queue #(
        .WIDTH (IW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out),
        .o_count (q_count)
    );

    kcs_back #(
        .MAX_KEEP   (MAX_KEEP),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_keep    (r_keep),
        .i_q_valid (q_valid),
        .i_q_item  (q_out),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_x       (ox),
        .o_y       (oy),
        .o_dist    (od),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = OTW'({od, oy, ox});

    // queue never overflows: the front end's credit covers in-flight requests
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push && !q_pop |-> q_count < QCNT_W'(QUEUE_DEPTH))
        else $error("queue overflow");

    // store only pops a request that is present
    a_q_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue underflow");

    // an accepted point is pushed into the queue after the stage-1 and stage-2 registers
    a_front_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> ##1 q_push)
        else $error("front end lost a point");

endmodule

// ===== sv/kcs_front.sv =====
// Distance front end: accepts points and computes exact squared distance.
// Depends on kcs_pkg; feeds kcs_queue, holding back input when it may fill.
module kcs_front import kcs_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [COORD_BITS-1:0]   i_ref_x,
    input  logic [COORD_BITS-1:0]   i_ref_y,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [COORD_BITS-1:0]   i_pt_x,
    input  logic [COORD_BITS-1:0]   i_pt_y,
    input  logic                    i_set_end,
    input  logic [QCNT_W-1:0]       i_q_count,
    output logic                    o_push,
    output logic [4*COORD_BITS+1:0] o_item
);

    localparam int CB = COORD_BITS;
    localparam int DW = 2 * CB + 1;
    localparam int SW = QCNT_W + 1;

    logic signed [CB:0] dx, dy;
    logic [CB-1:0]      ax, ay;
    logic [2*CB-1:0]    sqx, sqy;
    logic [DW-1:0]      dsum;
    logic               take;

    // stage 1: absolute coordinate differences
    logic          r_v1, r_e1;
    logic [CB-1:0] r_x1, r_y1, r_ax, r_ay;
    // stage 2: squares
    logic          r_v2, r_e2;
    logic [CB-1:0] r_x2, r_y2;
    logic [2*CB-1:0] r_sqx, r_sqy;

    // credit: never have more requests in flight than the queue can take
    assign o_ready = (SW'(i_q_count) + SW'(r_v1) + SW'(r_v2)) < SW'(QUEUE_DEPTH);
    assign take    = i_valid && o_ready;

    assign dx = $signed({i_pt_x[CB-1], i_pt_x}) - $signed({i_ref_x[CB-1], i_ref_x});
    assign dy = $signed({i_pt_y[CB-1], i_pt_y}) - $signed({i_ref_y[CB-1], i_ref_y});
    assign ax = dx[CB] ? CB'(-dx) : CB'(dx);
    assign ay = dy[CB] ? CB'(-dy) : CB'(dy);

    assign sqx  = r_ax * r_ax;
    assign sqy  = r_ay * r_ay;
    assign dsum = DW'(r_sqx) + DW'(r_sqy);

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= take;
            r_v2 <= r_v1;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_x1  <= i_pt_x;
        r_y1  <= i_pt_y;
        r_e1  <= i_set_end;
        r_ax  <= ax;
        r_ay  <= ay;
        r_x2  <= r_x1;
        r_y2  <= r_y1;
        r_e2  <= r_e1;
        r_sqx <= sqx;
        r_sqy <= sqy;
    end

    // item layout from bit 0: x, y, dist, set_end
    assign o_push = r_v2;
    assign o_item = {r_e2, dsum, r_y2, r_x2};

endmodule

// ===== sv/kcs_queue.sv =====
// Short FIFO between the distance front end and the selection store.
// Depends on kcs_pkg for depth.
module kcs_queue import kcs_pkg::*; #(
    parameter int WIDTH = 4 * DEF_COORD_BITS + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [WIDTH-1:0]  o_data,
    output logic [QCNT_W-1:0] o_count
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [PW-1:0]     r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + PW'(1);
            if (i_pop)  r_rp <= r_rp + PW'(1);
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

// ===== sv/kcs_back.sv =====
// Selection store: keeps held points sorted by eviction order and emits them.
// Depends on kcs_pkg; drains kcs_queue and drives the output register.
module kcs_back import kcs_pkg::*; #(
    parameter int MAX_KEEP   = DEF_MAX_KEEP,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [KEEP_W-1:0]       i_keep,
    input  logic                    i_q_valid,
    input  logic [4*COORD_BITS+1:0] i_q_item,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [COORD_BITS-1:0]   o_x,
    output logic [COORD_BITS-1:0]   o_y,
    output logic [OUT_DIST_W-1:0]   o_dist,
    output logic                    o_last
);

    localparam int CB = COORD_BITS;
    localparam int DW = 2 * CB + 1;
    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int HW = (CW > KEEP_W) ? CW : KEEP_W;

    // Slot 0 is evicted first and emitted first: descending distance,
    // oldest first among equal distances.
    logic [CB-1:0] r_sx [MAX_KEEP];
    logic [CB-1:0] r_sy [MAX_KEEP];
    logic [DW-1:0] r_sd [MAX_KEEP];
    logic [CB-1:0] n_sx [MAX_KEEP];
    logic [CB-1:0] n_sy [MAX_KEEP];
    logic [DW-1:0] n_sd [MAX_KEEP];
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_emit;

    logic          r_o_valid, r_o_last;
    logic [CB-1:0] r_o_x, r_o_y;
    logic [DW-1:0] r_o_d;

    logic [CB-1:0]       ix, iy;
    logic [DW-1:0]       id;
    logic                iend;
    logic [MAX_KEEP-1:0] ge;
    logic                do_app, do_evict, do_take, emit_step;

    assign ix   = i_q_item[CB-1:0];
    assign iy   = i_q_item[2*CB-1:CB];
    assign id   = i_q_item[2*CB+DW-1:2*CB];
    assign iend = i_q_item[2*CB+DW];

    // request handling decision
    assign o_q_pop   = i_q_valid && !r_emit;
    assign do_app    = (HW'(r_cnt) < HW'(i_keep)) && (r_cnt < CW'(MAX_KEEP));
    assign do_evict  = !do_app && (r_cnt != '0) && ge[0];
    assign do_take   = o_q_pop && (do_app || do_evict);
    assign emit_step = r_emit && (!r_o_valid || i_ready);

    // per-slot next value: compare with the new point, shift by neighbors
    for (genvar g = 0; g < MAX_KEEP; g++) begin : g_slot
        logic          ge_up, ge_dn;
        logic [CB-1:0] up_x, up_y, dn_x, dn_y;
        logic [DW-1:0] up_d, dn_d;

        assign ge[g] = (r_sd[g] >= id) && (CW'(g) < r_cnt);

        if (g < MAX_KEEP - 1) begin : g_up
            assign ge_up = ge[g+1];
            assign up_x  = r_sx[g+1];
            assign up_y  = r_sy[g+1];
            assign up_d  = r_sd[g+1];
        end else begin : g_top
            assign ge_up = 1'b0;
            assign up_x  = '0;
            assign up_y  = '0;
            assign up_d  = '0;
        end

        if (g > 0) begin : g_dn
            assign ge_dn = ge[g-1];
            assign dn_x  = r_sx[g-1];
            assign dn_y  = r_sy[g-1];
            assign dn_d  = r_sd[g-1];
        end else begin : g_bot
            assign ge_dn = 1'b1;
            assign dn_x  = '0;
            assign dn_y  = '0;
            assign dn_d  = '0;
        end

        // emit and evict move toward slot 0; plain insert moves away
        assign n_sx[g] = emit_step ? up_x :
                         do_evict  ? (ge_up ? up_x : (ge[g] ? ix : r_sx[g])) :
                                     (ge[g] ? r_sx[g] : (ge_dn ? ix : dn_x));
        assign n_sy[g] = emit_step ? up_y :
                         do_evict  ? (ge_up ? up_y : (ge[g] ? iy : r_sy[g])) :
                                     (ge[g] ? r_sy[g] : (ge_dn ? iy : dn_y));
        assign n_sd[g] = emit_step ? up_d :
                         do_evict  ? (ge_up ? up_d : (ge[g] ? id : r_sd[g])) :
                                     (ge[g] ? r_sd[g] : (ge_dn ? id : dn_d));
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (emit_step || do_take) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_sd <= n_sd;
        end
    end

    // held count after this cycle
    always_comb begin
        n_cnt = r_cnt;
        if (emit_step) begin
            n_cnt = r_cnt - CW'(1);
        end else if (do_take && do_app) begin
            n_cnt = r_cnt + CW'(1);
        end
    end

    // control: count and emit phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_emit <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (emit_step) begin
                r_emit <= (r_cnt != CW'(1));
            end else if (o_q_pop) begin
                r_emit <= iend && (n_cnt != '0);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit_step) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_step) begin
            r_o_x    <= r_sx[0];
            r_o_y    <= r_sy[0];
            r_o_d    <= r_sd[0];
            r_o_last <= (r_cnt == CW'(1));
        end
    end

    assign o_valid = r_o_valid;
    assign o_x     = r_o_x;
    assign o_y     = r_o_y;
    assign o_dist  = OUT_DIST_W'(r_o_d);
    assign o_last  = r_o_last;

endmodule
